>>> rtl/assert_macros.svh
// Assertion shorthands used by keyed_deque_engine_unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define KDE_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("keyed deque assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define KDE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("keyed deque assertion failed");

`endif

>>> rtl/kde_pkg.sv
package kde_pkg;

    // Fixed widths of the word fields.
    localparam int OP_W    = 3;
    localparam int PID_W   = 16;
    localparam int AGE_W   = 8;
    localparam int STAT_W  = 2;
    localparam int TOTAL_W = 5;

    // Default sizing of the queue.
    localparam int DEPTH_DEF   = 16;
    localparam int ID_BITS_DEF = 16;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 3'd0,
        OP_INSERT = 3'd1,
        OP_POP    = 3'd2,
        OP_DELETE = 3'd3,
        OP_SEARCH = 3'd4,
        OP_LIST   = 3'd5
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SHIFT,
        S_OUT
    } state_t;

endpackage

>>> rtl/kde_if.sv
// Request channel: one word per queue operation.
interface kde_req_if;
    import kde_pkg::*;

    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  operation;
    logic [PID_W-1:0] patient_id;
    logic [AGE_W-1:0] patient_age;

    modport source (output valid, output operation, output patient_id,
                    output patient_age, input ready);
    modport sink   (input valid, input operation, input patient_id,
                    input patient_age, output ready);
endinterface

// Response channel: one or more words per operation, the final one flagged by last.
interface kde_rsp_if;
    import kde_pkg::*;

    logic               valid;
    logic               ready;
    logic [STAT_W-1:0]  status;
    logic [PID_W-1:0]   found_id;
    logic [AGE_W-1:0]   found_age;
    logic [TOTAL_W-1:0] entry_total;
    logic               last;

    modport source (output valid, output status, output found_id, output found_age,
                    output entry_total, output last, input ready);
    modport sink   (input valid, input status, input found_id, input found_age,
                    input entry_total, input last, output ready);
endinterface

>>> rtl/kde_ram.sv
// Entry storage: one write port, one read port with registered read data.
module kde_ram #(
    parameter int DEPTH  = kde_pkg::DEPTH_DEF,
    parameter int DATA_W = kde_pkg::ID_BITS_DEF + kde_pkg::AGE_W
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/keyed_deque_engine_unit.sv
// Bounded double-ended queue with keyed delete and search. Entries (an identifier of
// min(ID_BITS,16) bits and an 8-bit age) live in a circular buffer in a single-port-write,
// single-port-read memory of DEPTH words; the head pointer moves for head insert and pop,
// so append, insert and pop need no walk: each finishes in the working state and then
// goes to the response handshake. Delete and search walk the queue from the head one entry
// per cycle through the memory read port, comparing each stored identifier against the key
// with one shared comparator; a delete that hits an entry short of the tail then closes
// the gap by moving every later entry down one place, one entry per cycle through the same
// read port and the write port. A list walks the queue through the same read port and
// returns one word per entry, reading the next entry only after the consumer takes the
// previous word; each response word is held until the consumer takes it. The request
// channel is ready only when no operation is in progress. Appending or inserting into a
// full queue returns status full, and pop, delete, search or list on an empty queue
// returns status empty; every response word carries the entry count after the operation,
// truncated to 5 bits, and last marks the final word of the operation. Unused operation
// codes return one ok word and change nothing. No clearing pass is needed after reset:
// only entries below the count are ever read.
`include "assert_macros.svh"

module keyed_deque_engine_unit #(
    parameter int DEPTH   = kde_pkg::DEPTH_DEF,
    parameter int ID_BITS = kde_pkg::ID_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    kde_req_if.sink   req,
    kde_rsp_if.source rsp
);
    import kde_pkg::*;

    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = CNT_W + 1;
    localparam int KEY_W  = (ID_BITS < PID_W) ? ID_BITS : PID_W;
    localparam int DATA_W = KEY_W + AGE_W;

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

    // Physical slot of the entry that sits ofs places behind the head.
    function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] base,
                                              input logic [CNT_W-1:0] ofs);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(ofs);
        if (sum >= SUM_W'(DEPTH))
        begin
            sum = sum - SUM_W'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  head_reg, head_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic [OP_W-1:0]   op_reg, op_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [AGE_W-1:0]  age_reg, age_next;
    logic              more_reg, more_next;
    status_t           status_reg, status_next;
    logic [KEY_W-1:0]  fid_reg, fid_next;
    logic [AGE_W-1:0]  fage_reg, fage_next;
    logic              last_reg, last_next;

    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic [IDX_W-1:0]  rd_addr;
    logic [DATA_W-1:0] rd_data;
    logic [KEY_W-1:0]  rd_key;
    logic [AGE_W-1:0]  rd_age;

    logic is_empty;
    logic is_full;
    logic at_end;
    logic hit;
    logic keyed_op;
    logic exec_stay;
    logic exec_shift;

    // The read port always fetches the entry that pos will point at next cycle, so the
    // data for pos_reg is on rd_data whenever the sequencer looks at it.
    kde_ram #(
        .DEPTH  (DEPTH),
        .DATA_W (DATA_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_key  = rd_data[DATA_W-1:AGE_W];
    assign rd_age  = rd_data[AGE_W-1:0];
    assign rd_addr = phys(head_reg, pos_next);

    // Shared compare unit and queue status.
    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == FULL_CNT);
    assign at_end   = ((pos_reg + CNT_ONE) == count_reg);
    assign hit      = (rd_key == key_reg);
    assign keyed_op = (op_reg == OP_DELETE) || (op_reg == OP_SEARCH);

    // The walk continues past a miss until the tail; a delete hit short of the tail
    // starts the compaction pass.
    assign exec_stay  = keyed_op && !is_empty && !hit && !at_end;
    assign exec_shift = (op_reg == OP_DELETE) && !is_empty && hit && !at_end;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (exec_shift)
                begin
                    state_next = S_SHIFT;
                end
                else if (!exec_stay)
                begin
                    state_next = S_OUT;
                end
            end
            S_SHIFT:
            begin
                if (at_end)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (rsp.ready)
                begin
                    state_next = more_reg ? S_EXEC : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath and memory control.
    always_comb
    begin
        head_next   = head_reg;
        count_next  = count_reg;
        pos_next    = pos_reg;
        op_next     = op_reg;
        key_next    = key_reg;
        age_next    = age_reg;
        more_next   = more_reg;
        status_next = status_reg;
        fid_next    = fid_reg;
        fage_next   = fage_reg;
        last_next   = last_reg;
        wr_en       = 1'b0;
        wr_addr     = phys(head_reg, count_reg);
        wr_data     = {key_reg, age_reg};

        unique case (state_reg)
            S_IDLE:
            begin
                pos_next = '0;
                if (req.valid)
                begin
                    op_next  = req.operation;
                    key_next = req.patient_id[KEY_W-1:0];
                    age_next = req.patient_age;
                end
            end
            S_EXEC:
            begin
                status_next = ST_OK;
                fid_next    = '0;
                fage_next   = '0;
                last_next   = 1'b1;
                more_next   = 1'b0;
                case (op_reg)
                    OP_APPEND:
                    begin
                        if (is_full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            count_next = count_reg + CNT_ONE;
                        end
                    end
                    OP_INSERT:
                    begin
                        if (is_full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            head_next  = (head_reg == '0) ? LAST_IDX : head_reg - IDX_W'(1);
                            wr_en      = 1'b1;
                            wr_addr    = head_next;
                            count_next = count_reg + CNT_ONE;
                        end
                    end
                    OP_POP:
                    begin
                        if (is_empty)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            fid_next   = rd_key;
                            fage_next  = rd_age;
                            head_next  = phys(head_reg, CNT_ONE);
                            count_next = count_reg - CNT_ONE;
                        end
                    end
                    OP_DELETE, OP_SEARCH:
                    begin
                        if (is_empty)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else if (hit)
                        begin
                            if (op_reg == OP_SEARCH)
                            begin
                                fid_next  = rd_key;
                                fage_next = rd_age;
                            end
                            else if (at_end)
                            begin
                                count_next = count_reg - CNT_ONE;
                            end
                            else
                            begin
                                pos_next = pos_reg + CNT_ONE;
                            end
                        end
                        else if (at_end)
                        begin
                            status_next = ST_NOTFOUND;
                        end
                        else
                        begin
                            pos_next = pos_reg + CNT_ONE;
                        end
                    end
                    OP_LIST:
                    begin
                        if (is_empty)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            fid_next  = rd_key;
                            fage_next = rd_age;
                            last_next = at_end;
                            more_next = !at_end;
                        end
                    end
                    default:
                    begin
                        status_next = ST_OK;
                    end
                endcase
            end
            S_SHIFT:
            begin
                // Move the entry at pos one place toward the head.
                wr_en   = 1'b1;
                wr_addr = phys(head_reg, pos_reg - CNT_ONE);
                wr_data = rd_data;
                if (at_end)
                begin
                    count_next = count_reg - CNT_ONE;
                end
                else
                begin
                    pos_next = pos_reg + CNT_ONE;
                end
            end
            S_OUT:
            begin
                if (rsp.ready && more_reg)
                begin
                    pos_next = pos_reg + CNT_ONE;
                end
            end
            default:
            begin
                pos_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
            pos_reg   <= '0;
            more_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            pos_reg   <= pos_next;
            more_reg  <= more_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        key_reg    <= key_next;
        age_reg    <= age_next;
        status_reg <= status_next;
        fid_reg    <= fid_next;
        fage_reg   <= fage_next;
        last_reg   <= last_next;
    end

    // Channel outputs.
    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = (state_reg == S_OUT);
    assign rsp.status      = status_reg;
    assign rsp.found_id    = PID_W'(fid_reg);
    assign rsp.found_age   = fage_reg;
    assign rsp.entry_total = TOTAL_W'(count_reg);
    assign rsp.last        = last_reg;

    // The count never exceeds the capacity.
    `KDE_ASSERT_IMPLY(a_count_bound, clk, rst_n, 1'b1, count_reg <= FULL_CNT)
    // No new request word is taken while a response word is pending.
    `KDE_ASSERT_IMPLY(a_one_side, clk, rst_n, req.ready, !rsp.valid)
    // Only a list produces more than one response word.
    `KDE_ASSERT_IMPLY(a_multi_is_list, clk, rst_n, rsp.valid && !rsp.last, op_reg == OP_LIST)
    // After the final word is taken the block is ready again.
    `KDE_ASSERT_NEXT(a_last_frees, clk, rst_n, rsp.valid && rsp.ready && rsp.last, req.ready)

endmodule
